### hdl/mba_pkg.sv
// Shared field widths, command codes, status codes and register indexes for the admission unit.
package mba_pkg;

    localparam int CMD_W       = 3;
    localparam int ID_W        = 4;
    localparam int BYTES_W     = 64;
    localparam int STATUS_W    = 3;
    localparam int COUNT_OUT_W = 32;
    localparam int CFG_INDEX_W = 2;

    localparam logic [CMD_W-1:0] CMD_ACQUIRE  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_RELEASE  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_SAMPLE   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_PRESSURE = 3'd3;
    localparam logic [CMD_W-1:0] CMD_QUERY    = 3'd4;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_OVERFLOW  = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_PRESSURE  = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_BUDGET    = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_MISMATCH  = 3'd4;

    localparam logic [CFG_INDEX_W-1:0] CFG_BUDGET   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_BASELINE = 2'd1;

    typedef logic [BYTES_W-1:0] bytes_t;

endpackage

### hdl/mba_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module mba_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hdl/memory_budget_admission_unit.sv
// Admission controller for a byte budget with per-client accounting.
//
// Requests are taken at one per cycle while results are drained without back-pressure. An
// accepted request is held in the input register while the client entry is read from the
// client RAM, then all checks and state updates happen in a single pass into the result
// register. The rate is set by the read-modify-write of the client RAM, which keeps up
// with back-to-back requests to the same client thanks to a forwarding register. Client
// entries need no clearing pass: a present bit per client, cleared at reset, masks entries
// never written. Configuration writes are always ready and must be issued only while no
// request is in flight.
module memory_budget_admission_unit #(
    parameter int NUM_CLIENTS   = 16,
    parameter int COUNTER_WIDTH = 32
) (
    input  logic                                 clk,
    input  logic                                 rst_n,

    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [mba_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [mba_pkg::BYTES_W-1:0]          cfg_data,

    input  logic                                 req_valid,
    output logic                                 req_ready,
    input  logic [mba_pkg::CMD_W-1:0]            command,
    input  logic [mba_pkg::ID_W-1:0]             client_id,
    input  logic [mba_pkg::BYTES_W-1:0]          amount,
    input  logic [mba_pkg::BYTES_W-1:0]          usage_sample,

    output logic                                 res_valid,
    input  logic                                 res_ready,
    output logic                                 granted,
    output logic [mba_pkg::STATUS_W-1:0]         status,
    output logic [mba_pkg::BYTES_W-1:0]          committed_total_out,
    output logic [mba_pkg::BYTES_W-1:0]          client_committed,
    output logic [mba_pkg::BYTES_W-1:0]          sampled_usage_out,
    output logic [mba_pkg::BYTES_W-1:0]          untracked_out,
    output logic                                 pressure_out,
    output logic [mba_pkg::COUNT_OUT_W-1:0]      granted_count,
    output logic [mba_pkg::COUNT_OUT_W-1:0]      rejected_count,
    output logic [mba_pkg::COUNT_OUT_W-1:0]      sample_count
);

    import mba_pkg::*;

    localparam int IDX_W = (NUM_CLIENTS > 1) ? $clog2(NUM_CLIENTS) : 1;

    // Input register.
    logic                s1_valid_reg;
    logic [CMD_W-1:0]    cmd_reg;
    logic [ID_W-1:0]     id_reg;
    bytes_t              amt_reg;
    bytes_t              smp_reg;

    // Forwarding of a client entry written in the cycle its successor was read.
    logic                fwd_hit_reg;
    bytes_t              fwd_data_reg;

    // Architectural state.
    bytes_t              budget_reg;
    bytes_t              baseline_reg;
    bytes_t              committed_reg;
    logic [BYTES_W:0]    bpc_reg;           // baseline plus committed, exact
    bytes_t              sampled_reg;
    bytes_t              untracked_reg;
    logic                pressure_reg;
    logic [NUM_CLIENTS-1:0] present_reg;
    logic [COUNTER_WIDTH-1:0] grant_cnt_reg;
    logic [COUNTER_WIDTH-1:0] reject_cnt_reg;
    logic [COUNTER_WIDTH-1:0] sample_cnt_reg;

    // Result register.
    logic                res_valid_reg;
    logic                res_granted_reg;
    logic [STATUS_W-1:0] res_status_reg;
    bytes_t              res_committed_reg;
    bytes_t              res_held_reg;
    bytes_t              res_sampled_reg;
    bytes_t              res_untracked_reg;
    logic                res_pressure_reg;
    logic [COUNTER_WIDTH-1:0] res_grant_cnt_reg;
    logic [COUNTER_WIDTH-1:0] res_reject_cnt_reg;
    logic [COUNTER_WIDTH-1:0] res_sample_cnt_reg;

    // Next values.
    logic                granted_next;
    logic [STATUS_W-1:0] status_next;
    bytes_t              committed_next;
    logic [BYTES_W:0]    bpc_next;
    bytes_t              sampled_next;
    bytes_t              untracked_next;
    logic                pressure_next;
    logic [NUM_CLIENTS-1:0] present_next;
    logic [COUNTER_WIDTH-1:0] grant_cnt_next;
    logic [COUNTER_WIDTH-1:0] reject_cnt_next;
    logic [COUNTER_WIDTH-1:0] sample_cnt_next;
    bytes_t              entry_next;
    logic                entry_present_next;
    logic                entry_write;
    logic                refresh;
    bytes_t              held_next;

    logic                fire;
    logic                req_accept;
    logic                cfg_accept;
    logic                id_ok;
    logic [IDX_W-1:0]    idx;
    logic                present_cur;
    bytes_t              ram_q;
    bytes_t              entry_cur;
    logic [BYTES_W:0]    sum_smp;
    logic [BYTES_W:0]    sum_base;
    logic [BYTES_W:0]    sum_comm;
    logic [BYTES_W+1:0]  sum_proj;
    logic                overflow;
    bytes_t              proj;
    logic                budget_hit;
    bytes_t              entry_add;
    bytes_t              entry_sub;
    logic                release_bad;
    bytes_t              expect_usage;

    assign cfg_ready  = 1'b1;
    assign cfg_accept = cfg_valid && cfg_ready;

    assign fire       = s1_valid_reg && (!res_valid_reg || res_ready);
    assign req_ready  = !s1_valid_reg || fire;
    assign req_accept = req_valid && req_ready;

    mba_ram #(
        .WIDTH (BYTES_W),
        .DEPTH (NUM_CLIENTS)
    ) u_client_ram (
        .clk   (clk),
        .we    (fire && entry_write),
        .waddr (idx),
        .wdata (entry_next),
        .re    (req_accept),
        .raddr (IDX_W'(client_id)),
        .rdata (ram_q)
    );

    assign id_ok       = ({{(32-ID_W){1'b0}}, id_reg} < 32'(NUM_CLIENTS));
    assign idx         = IDX_W'(id_reg);
    assign present_cur = id_ok ? present_reg[idx] : 1'b0;
    // An entry that is not present always holds zero, so the RAM word is masked.
    assign entry_cur   = present_cur ? (fwd_hit_reg ? fwd_data_reg : ram_q) : '0;

    assign sum_smp  = {1'b0, sampled_reg} + {1'b0, amt_reg};
    assign sum_base = {1'b0, baseline_reg} + {1'b0, amt_reg};
    assign sum_comm = {1'b0, committed_reg} + {1'b0, amt_reg};
    assign sum_proj = {1'b0, bpc_reg} + {2'b00, amt_reg};

    assign overflow = sum_smp[BYTES_W] || sum_base[BYTES_W] || sum_comm[BYTES_W] ||
                      (sum_proj[BYTES_W+1:BYTES_W] != 2'b00);
    assign proj       = (sum_smp[BYTES_W-1:0] > sum_proj[BYTES_W-1:0]) ?
                        sum_smp[BYTES_W-1:0] : sum_proj[BYTES_W-1:0];
    assign budget_hit = (budget_reg != '0) && (proj > budget_reg);

    assign entry_add   = entry_cur + amt_reg;
    assign entry_sub   = entry_cur - amt_reg;
    assign release_bad = !present_cur || (entry_cur < amt_reg) || (committed_reg < amt_reg);

    always_comb
    begin
        granted_next       = 1'b0;
        status_next        = STATUS_OK;
        committed_next     = committed_reg;
        bpc_next           = bpc_reg;
        sampled_next       = sampled_reg;
        pressure_next      = pressure_reg;
        present_next       = present_reg;
        grant_cnt_next     = grant_cnt_reg;
        reject_cnt_next    = reject_cnt_reg;
        sample_cnt_next    = sample_cnt_reg;
        entry_next         = entry_cur;
        entry_present_next = present_cur;
        entry_write        = 1'b0;
        refresh            = 1'b0;

        case (cmd_reg)
            CMD_ACQUIRE:
            begin
                if (id_ok)
                begin
                    if (overflow || pressure_reg)
                    begin
                        status_next     = overflow ? STATUS_OVERFLOW : STATUS_PRESSURE;
                        reject_cnt_next = reject_cnt_reg + COUNTER_WIDTH'(1);
                    end
                    else if (budget_hit)
                    begin
                        status_next     = STATUS_BUDGET;
                        reject_cnt_next = reject_cnt_reg + COUNTER_WIDTH'(1);
                    end
                    else
                    begin
                        granted_next       = 1'b1;
                        committed_next     = sum_comm[BYTES_W-1:0];
                        bpc_next           = sum_proj[BYTES_W:0];
                        entry_next         = entry_add;
                        entry_present_next = 1'b1;
                        present_next[idx]  = 1'b1;
                        entry_write        = 1'b1;
                        grant_cnt_next     = grant_cnt_reg + COUNTER_WIDTH'(1);
                        refresh            = 1'b1;
                    end
                end
            end
            CMD_RELEASE:
            begin
                if (id_ok)
                begin
                    if (release_bad)
                    begin
                        pressure_next = 1'b1;
                        status_next   = STATUS_MISMATCH;
                    end
                    else
                    begin
                        committed_next     = committed_reg - amt_reg;
                        bpc_next           = bpc_reg - {1'b0, amt_reg};
                        entry_next         = entry_sub;
                        entry_present_next = (entry_sub != '0);
                        present_next[idx]  = (entry_sub != '0);
                        entry_write        = 1'b1;
                        refresh            = 1'b1;
                    end
                end
            end
            CMD_SAMPLE:
            begin
                sampled_next    = smp_reg;
                sample_cnt_next = sample_cnt_reg + COUNTER_WIDTH'(1);
                refresh         = 1'b1;
                if ((budget_reg != '0) && (smp_reg > budget_reg))
                begin
                    pressure_next = 1'b1;
                end
            end
            CMD_PRESSURE:
            begin
                pressure_next = 1'b1;
            end
            default:
            begin
                // Queries and unused codes leave the state alone.
            end
        endcase
    end

    // Expected usage saturates at the top of the 64-bit range.
    assign expect_usage   = bpc_next[BYTES_W] ? '1 : bpc_next[BYTES_W-1:0];
    assign untracked_next = !refresh ? untracked_reg :
                            (sampled_next > expect_usage) ? sampled_next - expect_usage : '0;
    assign held_next      = (id_ok && entry_present_next) ? entry_next : '0;

    // Input register and forwarding.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            fwd_hit_reg  <= 1'b0;
        end
        else
        begin
            if (req_accept)
            begin
                s1_valid_reg <= 1'b1;
                fwd_hit_reg  <= fire && entry_write && (idx == IDX_W'(client_id));
            end
            else if (fire)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_accept)
        begin
            cmd_reg      <= command;
            id_reg       <= client_id;
            amt_reg      <= amount;
            smp_reg      <= usage_sample;
            fwd_data_reg <= entry_next;
        end
    end

    // Architectural state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            budget_reg     <= '0;
            baseline_reg   <= '0;
            committed_reg  <= '0;
            bpc_reg        <= '0;
            sampled_reg    <= '0;
            untracked_reg  <= '0;
            pressure_reg   <= 1'b0;
            present_reg    <= '0;
            grant_cnt_reg  <= '0;
            reject_cnt_reg <= '0;
            sample_cnt_reg <= '0;
        end
        else if (cfg_accept)
        begin
            if (cfg_index == CFG_BUDGET)
            begin
                budget_reg <= cfg_data;
            end
            else if (cfg_index == CFG_BASELINE)
            begin
                baseline_reg <= cfg_data;
                sampled_reg  <= cfg_data;
                bpc_reg      <= {1'b0, cfg_data} + {1'b0, committed_reg};
            end
        end
        else if (fire)
        begin
            committed_reg  <= committed_next;
            bpc_reg        <= bpc_next;
            sampled_reg    <= sampled_next;
            untracked_reg  <= untracked_next;
            pressure_reg   <= pressure_next;
            present_reg    <= present_next;
            grant_cnt_reg  <= grant_cnt_next;
            reject_cnt_reg <= reject_cnt_next;
            sample_cnt_reg <= sample_cnt_next;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            res_granted_reg    <= granted_next;
            res_status_reg     <= status_next;
            res_committed_reg  <= committed_next;
            res_held_reg       <= held_next;
            res_sampled_reg    <= sampled_next;
            res_untracked_reg  <= untracked_next;
            res_pressure_reg   <= pressure_next;
            res_grant_cnt_reg  <= grant_cnt_next;
            res_reject_cnt_reg <= reject_cnt_next;
            res_sample_cnt_reg <= sample_cnt_next;
        end
    end

    assign res_valid           = res_valid_reg;
    assign granted             = res_granted_reg;
    assign status              = res_status_reg;
    assign committed_total_out = res_committed_reg;
    assign client_committed    = res_held_reg;
    assign sampled_usage_out   = res_sampled_reg;
    assign untracked_out       = res_untracked_reg;
    assign pressure_out        = res_pressure_reg;
    assign granted_count       = COUNT_OUT_W'(res_grant_cnt_reg);
    assign rejected_count      = COUNT_OUT_W'(res_reject_cnt_reg);
    assign sample_count        = COUNT_OUT_W'(res_sample_cnt_reg);

endmodule

### sim/memory_budget_admission_unit_tb.sv
// Self-checking testbench for the memory budget admission unit with randomized handshakes.
`timescale 1ns / 100ps

module memory_budget_admission_unit_tb;

    import mba_pkg::*;

    localparam int CLIENTS    = 16;
    localparam int LONG_HOLD  = 400;
    localparam int IDLE_LIMIT = 3000;
    localparam int PRINT_CAP  = 40;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [ID_W-1:0]  id;
        bytes_t           amount;
        bytes_t           usage_sample;
    } request_t;

    typedef struct packed {
        logic                   granted;
        logic [STATUS_W-1:0]    status;
        bytes_t                 total;
        bytes_t                 held;
        bytes_t                 sampled;
        bytes_t                 untracked;
        logic                   pressure;
        logic [COUNT_OUT_W-1:0] grants;
        logic [COUNT_OUT_W-1:0] rejects;
        logic [COUNT_OUT_W-1:0] samples;
    } result_t;

    typedef struct packed {
        bytes_t                       budget;
        bytes_t                       baseline;
        bytes_t                       total;
        logic [CLIENTS-1:0][63:0]     held;
        logic [CLIENTS-1:0]           present;
        bytes_t                       sampled;
        bytes_t                       untracked;
        logic                         pressure;
        logic [COUNT_OUT_W-1:0]       grants;
        logic [COUNT_OUT_W-1:0]       rejects;
        logic [COUNT_OUT_W-1:0]       samples;
    } ledger_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    bytes_t                 cfg_data = '0;
    logic                   req_valid = 1'b0;
    logic                   req_ready;
    logic [CMD_W-1:0]       command = '0;
    logic [ID_W-1:0]        client_id = '0;
    bytes_t                 amount = '0;
    bytes_t                 usage_sample = '0;
    logic                   res_valid;
    logic                   res_ready = 1'b0;
    logic                   granted;
    logic [STATUS_W-1:0]    status;
    bytes_t                 committed_total_out;
    bytes_t                 client_committed;
    bytes_t                 sampled_usage_out;
    bytes_t                 untracked_out;
    logic                   pressure_out;
    logic [COUNT_OUT_W-1:0] granted_count;
    logic [COUNT_OUT_W-1:0] rejected_count;
    logic [COUNT_OUT_W-1:0] sample_count;

    // The shadow ledger runs ahead at generation time; the check ledger follows acceptance.
    ledger_t  shadow_ledger = '0;
    ledger_t  ledger = '0;
    request_t request_q[$];
    result_t  outcome_q[$];
    request_t on_wire;
    result_t  want;
    result_t  got;

    int queued_cnt    = 0;
    int accepted_cnt  = 0;
    int checked_cnt   = 0;
    int mismatches    = 0;
    int reg_writes    = 0;
    int grant_seen    = 0;
    int reject_seen   = 0;
    int mismatch_seen = 0;
    int send_wait     = 0;
    int send_burst    = 0;
    int recv_wait     = 0;
    int recv_burst    = 0;
    int recv_hold     = 0;
    int hold_requests = 0;
    int hold_served   = 0;
    int idle_cycles   = 0;

    memory_budget_admission_unit #(
        .NUM_CLIENTS  (CLIENTS),
        .COUNTER_WIDTH(32)
    ) DUT (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .req_valid          (req_valid),
        .req_ready          (req_ready),
        .command            (command),
        .client_id          (client_id),
        .amount             (amount),
        .usage_sample       (usage_sample),
        .res_valid          (res_valid),
        .res_ready          (res_ready),
        .granted            (granted),
        .status             (status),
        .committed_total_out(committed_total_out),
        .client_committed   (client_committed),
        .sampled_usage_out  (sampled_usage_out),
        .untracked_out      (untracked_out),
        .pressure_out       (pressure_out),
        .granted_count      (granted_count),
        .rejected_count     (rejected_count),
        .sample_count       (sample_count)
    );

    always #5 clk = ~clk;

    function automatic bytes_t rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic bytes_t untracked_of(ledger_t lg);
        bytes_t booked;
        booked = (lg.total > ~lg.baseline) ? '1 : lg.baseline + lg.total;
        return (lg.sampled > booked) ? lg.sampled - booked : '0;
    endfunction

    function automatic void apply_reg(inout ledger_t lg, input logic [CFG_INDEX_W-1:0] idx,
                                      input bytes_t data);
        case (idx)
            CFG_BUDGET: lg.budget = data;
            CFG_BASELINE:
            begin
                // Loading the baseline also reloads the sample but leaves untracked alone.
                lg.baseline = data;
                lg.sampled  = data;
            end
            default: ;
        endcase
    endfunction

    function automatic result_t admit_step(inout ledger_t lg, input request_t rq);
        result_t rs;
        logic    ovf;
        bytes_t  p_sampled;
        bytes_t  p_booked;
        rs = '0;
        rs.status = STATUS_OK;
        case (rq.cmd)
            CMD_ACQUIRE:
            begin
                ovf = (rq.amount > ~lg.sampled) || (rq.amount > ~lg.baseline) ||
                      (lg.total > ~rq.amount) || (lg.baseline + rq.amount > ~lg.total);
                if (ovf || lg.pressure)
                begin
                    rs.status = ovf ? STATUS_OVERFLOW : STATUS_PRESSURE;
                    lg.rejects = lg.rejects + 1;
                end
                else
                begin
                    p_sampled = lg.sampled + rq.amount;
                    p_booked  = lg.baseline + lg.total + rq.amount;
                    if (lg.budget != 0 && (p_sampled > lg.budget || p_booked > lg.budget))
                    begin
                        rs.status = STATUS_BUDGET;
                        lg.rejects = lg.rejects + 1;
                    end
                    else
                    begin
                        lg.total = lg.total + rq.amount;
                        lg.held[rq.id] = lg.held[rq.id] + rq.amount;
                        lg.present[rq.id] = 1'b1;
                        lg.grants = lg.grants + 1;
                        rs.granted = 1'b1;
                        lg.untracked = untracked_of(lg);
                    end
                end
            end
            CMD_RELEASE:
            begin
                if (!lg.present[rq.id] || lg.held[rq.id] < rq.amount || lg.total < rq.amount)
                begin
                    lg.pressure = 1'b1;
                    rs.status = STATUS_MISMATCH;
                end
                else
                begin
                    lg.held[rq.id] = lg.held[rq.id] - rq.amount;
                    lg.total = lg.total - rq.amount;
                    if (lg.held[rq.id] == 0)
                        lg.present[rq.id] = 1'b0;
                    lg.untracked = untracked_of(lg);
                end
            end
            CMD_SAMPLE:
            begin
                lg.sampled = rq.usage_sample;
                lg.samples = lg.samples + 1;
                lg.untracked = untracked_of(lg);
                if (lg.budget != 0 && rq.usage_sample > lg.budget)
                    lg.pressure = 1'b1;
            end
            CMD_PRESSURE: lg.pressure = 1'b1;
            default: ;
        endcase
        rs.total     = lg.total;
        rs.held      = lg.present[rq.id] ? lg.held[rq.id] : '0;
        rs.sampled   = lg.sampled;
        rs.untracked = lg.untracked;
        rs.pressure  = lg.pressure;
        rs.grants    = lg.grants;
        rs.rejects   = lg.rejects;
        rs.samples   = lg.samples;
        return rs;
    endfunction

    // Random per-request wait, with occasional stretches of no waiting at all.
    function automatic int draw_wait(inout int burst);
        if (burst > 0)
        begin
            burst--;
            return 0;
        end
        if ($urandom_range(0, 39) == 0)
        begin
            burst = $urandom_range(20, 60);
            return 0;
        end
        return $urandom_range(0, 8);
    endfunction

    task automatic report(input string msg);
        if (mismatches < PRINT_CAP)
            $display("[%0t] mismatch: %s", $time, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input bytes_t seen, input bytes_t due);
        if (seen !== due)
            report($sformatf("result %0d %s: got %0h, expected %0h",
                             checked_cnt, name, seen, due));
    endtask

    task automatic queue_req(input logic [CMD_W-1:0] cmd, input int id, input bytes_t amt,
                             input bytes_t smp);
        request_t rq;
        rq.cmd          = cmd;
        rq.id           = id[ID_W-1:0];
        rq.amount       = amt;
        rq.usage_sample = smp;
        void'(admit_step(shadow_ledger, rq));
        request_q.push_back(rq);
        queued_cnt++;
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input bytes_t data);
        apply_reg(shadow_ledger, idx, data);
        @(posedge clk);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        apply_reg(ledger, idx, data);
        cfg_valid <= 1'b0;
        reg_writes++;
    endtask

    task automatic drain();
        while (accepted_cnt != queued_cnt || outcome_q.size() != 0)
            @(posedge clk);
    endtask

    function automatic bytes_t pick_amount(bytes_t limit);
        case ($urandom_range(0, 9))
            0: return '0;
            1, 2, 3, 4: return bytes_t'($urandom_range(1, 4095));
            5, 6: return (limit != 0) ? rand64() % ((limit >> 2) + 1) : rand64() >> 16;
            7: return rand64();
            8: return ~bytes_t'($urandom_range(0, 15));
            default: return rand64() >> $urandom_range(0, 63);
        endcase
    endfunction

    // Mostly well-formed traffic: releases name a holding client and never exceed its share,
    // samples stay within the budget. Noisy traffic draws every field at random.
    task automatic random_request(input bit noisy);
        request_t rq;
        int       pick;
        int       start;
        int       k;
        bytes_t   held;
        rq.id           = ID_W'(($urandom_range(0, 1) == 0) ?
                                $urandom_range(0, 3) : $urandom_range(0, 15));
        rq.amount       = pick_amount(shadow_ledger.budget);
        rq.usage_sample = rand64();
        if (noisy)
            rq.cmd = CMD_W'($urandom_range(0, 7));
        else
        begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
                rq.cmd = CMD_ACQUIRE;
            else if (pick < 75)
            begin
                rq.cmd = CMD_RELEASE;
                start = $urandom_range(0, CLIENTS - 1);
                for (k = 0; k < CLIENTS && !shadow_ledger.present[rq.id]; k++)
                    rq.id = ID_W'((start + k) % CLIENTS);
                if (!shadow_ledger.present[rq.id])
                    rq.cmd = CMD_ACQUIRE;
                else
                begin
                    held = shadow_ledger.held[rq.id];
                    case ($urandom_range(0, 2))
                        0: rq.amount = held;
                        1: rq.amount = '0;
                        default: rq.amount = (held == '1) ? rand64() : rand64() % (held + 1);
                    endcase
                end
            end
            else if (pick < 88)
            begin
                rq.cmd = CMD_SAMPLE;
                if (shadow_ledger.budget == '1)
                    rq.usage_sample = rand64();
                else if (shadow_ledger.budget != 0)
                    rq.usage_sample = rand64() % (shadow_ledger.budget + 1);
                else
                    rq.usage_sample = rand64() >> $urandom_range(0, 63);
            end
            else
                rq.cmd = CMD_QUERY + CMD_W'($urandom_range(0, 3));
        end
        queue_req(rq.cmd, rq.id, rq.amount, rq.usage_sample);
    endtask

    task automatic run_random(input int n, input bit noisy);
        repeat (n) random_request(noisy);
    endtask

    task automatic release_all();
        int c;
        for (c = 0; c < CLIENTS; c++)
            if (shadow_ledger.present[c])
                queue_req(CMD_RELEASE, c, shadow_ledger.held[c], rand64());
    endtask

    // Request driver.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_valid && req_ready)
            begin
                outcome_q.push_back(admit_step(ledger, on_wire));
                accepted_cnt++;
            end
            if (!req_valid || req_ready)
            begin
                if (send_wait > 0)
                begin
                    send_wait--;
                    req_valid <= 1'b0;
                end
                else if (request_q.size() != 0)
                begin
                    on_wire = request_q.pop_front();
                    command      <= on_wire.cmd;
                    client_id    <= on_wire.id;
                    amount       <= on_wire.amount;
                    usage_sample <= on_wire.usage_sample;
                    req_valid    <= 1'b1;
                    send_wait = draw_wait(send_burst);
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    // Result receiver: random back-pressure plus a long hold on request from the stimulus.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (hold_served != hold_requests)
            begin
                hold_served = hold_requests;
                recv_hold = LONG_HOLD;
                res_ready <= 1'b0;
            end
            else if (res_valid && res_ready)
            begin
                recv_wait = draw_wait(recv_burst);
                res_ready <= (recv_wait == 0);
            end
            else if (!res_ready)
            begin
                if (recv_hold > 0)
                    recv_hold--;
                else if (recv_wait > 0)
                    recv_wait--;
                if (recv_hold == 0 && recv_wait == 0)
                    res_ready <= 1'b1;
            end
        end
    end

    // Result monitor.
    always @(posedge clk)
    begin
        if (rst_n && res_valid && res_ready)
        begin
            if (outcome_q.size() == 0)
                report("result arrived with no request outstanding");
            else
            begin
                want = outcome_q.pop_front();
                got.granted   = granted;
                got.status    = status;
                got.total     = committed_total_out;
                got.held      = client_committed;
                got.sampled   = sampled_usage_out;
                got.untracked = untracked_out;
                got.pressure  = pressure_out;
                got.grants    = granted_count;
                got.rejects   = rejected_count;
                got.samples   = sample_count;
                check_field("granted", bytes_t'(got.granted), bytes_t'(want.granted));
                check_field("status", bytes_t'(got.status), bytes_t'(want.status));
                check_field("committed_total_out", got.total, want.total);
                check_field("client_committed", got.held, want.held);
                check_field("sampled_usage_out", got.sampled, want.sampled);
                check_field("untracked_out", got.untracked, want.untracked);
                check_field("pressure_out", bytes_t'(got.pressure), bytes_t'(want.pressure));
                check_field("granted_count", bytes_t'(got.grants), bytes_t'(want.grants));
                check_field("rejected_count", bytes_t'(got.rejects), bytes_t'(want.rejects));
                check_field("sample_count", bytes_t'(got.samples), bytes_t'(want.samples));
                if (want.granted)
                    grant_seen++;
                if (want.status == STATUS_MISMATCH)
                    mismatch_seen++;
                else if (want.status != STATUS_OK)
                    reject_seen++;
                checked_cnt++;
            end
        end
    end

    // Watchdog on cycles without any handshake.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_valid && req_ready) || (res_valid && res_ready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Timed out after %0d cycles without progress", idle_cycles);
                $display("FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: no budget, zero baseline.
        queue_req(CMD_QUERY, 0, '0, '0);
        queue_req(CMD_ACQUIRE, 0, '0, rand64());
        queue_req(CMD_RELEASE, 0, '0, rand64());
        queue_req(CMD_ACQUIRE, 15, 64'd1000, '1);
        queue_req(CMD_ACQUIRE, 15, 64'd24, '0);
        queue_req(CMD_ACQUIRE, 3, '1, '0);
        queue_req(CMD_SAMPLE, 9, '0, '1);
        queue_req(CMD_ACQUIRE, 1, 64'd1, '0);
        queue_req(CMD_SAMPLE, 9, '1, '0);
        queue_req(CMD_RELEASE, 15, 64'd24, '0);
        queue_req(CMD_RELEASE, 15, 64'd1000, '0);
        queue_req(CMD_QUERY + 3'd1, 15, '1, '1);
        queue_req(CMD_QUERY + 3'd3, 0, '1, '0);
        drain();

        // A tight budget above a small baseline: projections right at and just past it.
        write_reg(CFG_BUDGET, 64'd1000);
        write_reg(CFG_BASELINE, 64'd100);
        queue_req(CMD_ACQUIRE, 2, 64'd901, '0);
        queue_req(CMD_ACQUIRE, 2, 64'd900, '0);
        queue_req(CMD_ACQUIRE, 4, 64'd1, '0);
        queue_req(CMD_SAMPLE, 2, '0, 64'd1000);
        queue_req(CMD_SAMPLE, 2, '0, 64'd50);
        queue_req(CMD_RELEASE, 2, 64'd900, '0);
        queue_req(CMD_QUERY + 3'd2, 2, '0, '0);
        drain();

        write_reg(CFG_BUDGET, '0);
        write_reg(CFG_BASELINE, '0);
        run_random(250, 1'b0);
        release_all();
        drain();

        write_reg(CFG_BUDGET, 64'd1 << 20);
        write_reg(CFG_BASELINE, bytes_t'($urandom_range(0, 65535)));
        run_random(250, 1'b0);
        drain();

        write_reg(CFG_BUDGET, '1);
        write_reg(CFG_BASELINE, rand64() >> 24);
        run_random(200, 1'b0);
        drain();

        write_reg(CFG_BASELINE, '1);
        run_random(60, 1'b0);
        release_all();
        drain();

        // Stall the result side for a long stretch while requests keep coming.
        write_reg(CFG_BUDGET, 64'd1 << 16);
        write_reg(CFG_BASELINE, '0);
        run_random(250, 1'b0);
        hold_requests++;
        release_all();
        drain();

        // The pressure flag is sticky, so the cases that raise it come last.
        write_reg(CFG_BUDGET, 64'd500);
        write_reg(CFG_BASELINE, 64'd100);
        queue_req(CMD_SAMPLE, 1, '0, 64'd500);
        queue_req(CMD_SAMPLE, 1, '0, 64'd600);
        queue_req(CMD_RELEASE, 1, shadow_ledger.held[1] + 64'd1, '0);
        queue_req(CMD_ACQUIRE, 1, 64'd10, '0);
        queue_req(CMD_ACQUIRE, 1, '1, '0);
        queue_req(CMD_PRESSURE, 1, '0, '0);
        queue_req(CMD_QUERY, 1, '0, '0);
        drain();

        write_reg(CFG_BUDGET, rand64() >> 34);
        run_random(200, 1'b1);
        drain();

        repeat (20) @(posedge clk);
        if (outcome_q.size() != 0)
            report($sformatf("%0d results never arrived", outcome_q.size()));
        $display("Checked %0d results from %0d requests over %0d register writes.",
                 checked_cnt, accepted_cnt, reg_writes);
        $display("Outcomes: %0d grants, %0d rejected acquires, %0d release mismatches.",
                 grant_seen, reject_seen, mismatch_seen);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
